// ===== sv/fqp_pkg.sv =====
// Package with the types, codes and constants of the FASTQ record parser.
package fqp_pkg;

	localparam int MAX_HEADER_DEF  = 256;
	localparam int LENGTH_BITS_DEF = 24;

	typedef enum logic [2:0] {
		CMD_TEXT     = 3'd0,
		CMD_LOAD_SEQ = 3'd1,
		CMD_LOAD_QUA = 3'd2,
		CMD_LOAD_MAP = 3'd3,
		CMD_EOF      = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_HEADER = 3'd0,
		KIND_SEQ    = 3'd1,
		KIND_QUAL   = 3'd2,
		KIND_END    = 3'd3,
		KIND_ERROR  = 3'd4
	} kind_t;

	localparam logic [2:0] ACT_STRIP = 3'd0;
	localparam logic [2:0] ACT_LEGAL = 3'd1;
	localparam logic [2:0] ACT_FATAL = 3'd2;

	localparam logic [7:0] ERR_NO_AT      = 8'd1;
	localparam logic [7:0] ERR_EOF        = 8'd2;
	localparam logic [7:0] ERR_SEQ_CHAR   = 8'd3;
	localparam logic [7:0] ERR_PLUS_LINE  = 8'd4;
	localparam logic [7:0] ERR_QUAL_CHAR  = 8'd5;
	localparam logic [7:0] ERR_LENGTHS    = 8'd6;

	localparam logic [7:0] CH_AT   = 8'h40;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_HEAD = 6'b000010,
		PH_SEQ  = 6'b000100,
		PH_PLUS = 6'b001000,
		PH_QUAL = 6'b010000,
		PH_HALT = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] byte_value;
		logic [7:0] table_value;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic [23:0] record_length;
		logic [31:0] record_number;
		logic [31:0] line_number;
		logic [7:0]  illegal_byte;
		logic [31:0] stripped_total;
	} result_t;

endpackage

// ===== sv/fastq_record_parser.sv =====
// FASTQ record parser top level: table memories, header store and parse logic.
//
// Requests enter on the item channel (valid/ready) one per cycle: text bytes,
// table loads for the sequence action, quality action and sequence map tables,
// and end of file. Results leave on the result channel (valid/ready): header,
// sequence and quality bytes, record ends and numbered errors.
// A request is handled as follows: at acceptance the three 256-entry tables
// and the header store are read (synchronous memories); once the output
// register can take a result, the parse state is updated and the result is
// written to the output register. One request per cycle is sustained while the
// receiver takes results. The header store is read at the plus-line position
// forwarded from the request being executed in the same cycle.
// Table loads are written at acceptance, so a following byte sees them.
// After reset the parser waits for '@'; the tables and header store hold
// unknown contents until loaded. When the receiver stalls, the output register
// holds its result and the item channel drops ready once the execute stage
// is also full. After an error the parser halts until reset; loads still work.
module fastq_record_parser #(
	parameter int MAX_HEADER  = fqp_pkg::MAX_HEADER_DEF,
	parameter int LENGTH_BITS = fqp_pkg::LENGTH_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  fqp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output fqp_pkg::result_t result
);

	localparam int AW = $clog2(MAX_HEADER);
	localparam int HW = $clog2(MAX_HEADER + 2);
	localparam logic [HW-1:0] HMAX = HW'(MAX_HEADER);

	logic [2:0] sa_mem  [256];
	logic [2:0] qa_mem  [256];
	logic [7:0] map_mem [256];
	logic [7:0] hdr_mem [MAX_HEADER];

	logic       v_s1;
	logic [2:0] cmd_s1;
	logic [7:0] byte_s1;
	logic [2:0] sa_s1;
	logic [2:0] qa_s1;
	logic [7:0] map_s1;
	logic [7:0] hdr_s1;

	fqp_pkg::phase_t  phase_q, phase_d;
	logic [HW-1:0]    hdr_len_q, hdr_len_d;
	logic [HW-1:0]    plus_len_q, plus_len_d;
	logic             plus_diff_q, plus_diff_d;
	logic [7:0]       plus_first_q, plus_first_d;
	logic [LENGTH_BITS-1:0] seq_cnt_q, seq_cnt_d;
	logic [LENGTH_BITS-1:0] qual_cnt_q, qual_cnt_d;
	logic             at_ls_q, at_ls_d;
	logic             flp_q, flp_d;
	logic             line_bad_q, line_bad_d;
	logic [7:0]       bad_byte_q, bad_byte_d;
	logic [31:0]      line_q, line_d;
	logic [31:0]      rec_start_q, rec_start_d;
	logic [31:0]      rec_cnt_q, rec_cnt_d;
	logic [31:0]      strip_cnt_q, strip_cnt_d;

	logic             adv, exec, accept;
	logic             hdr_we;
	logic             res_v;
	logic [2:0]       res_kind;
	logic [7:0]       res_val;
	logic [23:0]      res_len;
	logic [31:0]      res_line;
	logic [7:0]       res_bad;
	logic             bad;
	logic [31:0]      eof_line;
	logic [AW-1:0]    hdr_raddr;

	logic             out_v_q;
	fqp_pkg::result_t out_q;

	assign adv          = !out_v_q || result_ready;
	assign exec         = v_s1 && adv;
	assign item_ready   = !v_s1 || adv;
	assign accept       = item_valid && item_ready;
	assign result_valid = out_v_q;
	assign result       = out_q;
	assign hdr_raddr    = plus_len_d[AW-1:0];

	// Tables and header store; loads are written when the request is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			case (item.command)
				fqp_pkg::CMD_LOAD_SEQ: sa_mem[item.byte_value]  <= item.table_value[2:0];
				fqp_pkg::CMD_LOAD_QUA: qa_mem[item.byte_value]  <= item.table_value[2:0];
				fqp_pkg::CMD_LOAD_MAP: map_mem[item.byte_value] <= item.table_value;
				default: ;
			endcase
			sa_s1  <= sa_mem[item.byte_value];
			qa_s1  <= qa_mem[item.byte_value];
			map_s1 <= map_mem[item.byte_value];
			hdr_s1 <= hdr_mem[hdr_raddr];
			cmd_s1  <= item.command;
			byte_s1 <= item.byte_value;
		end
		if (hdr_we) begin
			hdr_mem[hdr_len_q[AW-1:0]] <= byte_s1;
		end
	end

	always_comb begin
		phase_d      = phase_q;
		hdr_len_d    = hdr_len_q;
		plus_len_d   = plus_len_q;
		plus_diff_d  = plus_diff_q;
		plus_first_d = plus_first_q;
		seq_cnt_d    = seq_cnt_q;
		qual_cnt_d   = qual_cnt_q;
		at_ls_d      = at_ls_q;
		flp_d        = flp_q;
		line_bad_d   = line_bad_q;
		bad_byte_d   = bad_byte_q;
		line_d       = line_q;
		rec_start_d  = rec_start_q;
		rec_cnt_d    = rec_cnt_q;
		strip_cnt_d  = strip_cnt_q;
		hdr_we       = 1'b0;
		res_v        = 1'b0;
		res_kind     = fqp_pkg::KIND_ERROR;
		res_val      = '0;
		res_len      = '0;
		res_line     = line_q;
		res_bad      = '0;
		bad          = 1'b0;
		eof_line     = line_q;

		if (exec && cmd_s1 == fqp_pkg::CMD_TEXT) begin
			case (phase_q)
				fqp_pkg::PH_IDLE: begin
					if (byte_s1 != fqp_pkg::CH_AT) begin
						phase_d = fqp_pkg::PH_HALT;
						res_v   = 1'b1;
						res_val = fqp_pkg::ERR_NO_AT;
					end else begin
						phase_d     = fqp_pkg::PH_HEAD;
						hdr_len_d   = '0;
						rec_start_d = line_q;
						seq_cnt_d   = '0;
						qual_cnt_d  = '0;
						line_bad_d  = 1'b0;
					end
				end
				fqp_pkg::PH_HEAD: begin
					hdr_we = hdr_len_q < HMAX;
					if (hdr_len_q <= HMAX) begin
						hdr_len_d = hdr_len_q + 1'b1;
					end
					if (byte_s1 == fqp_pkg::CH_LF) begin
						line_d     = line_q + 1'b1;
						phase_d    = fqp_pkg::PH_SEQ;
						at_ls_d    = 1'b1;
						flp_d      = 1'b1;
						line_bad_d = 1'b0;
					end
					res_v    = 1'b1;
					res_kind = fqp_pkg::KIND_HEADER;
					res_val  = byte_s1;
				end
				fqp_pkg::PH_SEQ: begin
					if (at_ls_q && !flp_q && byte_s1 == fqp_pkg::CH_PLUS) begin
						phase_d      = fqp_pkg::PH_PLUS;
						plus_len_d   = '0;
						plus_diff_d  = 1'b0;
						plus_first_d = '0;
						at_ls_d      = 1'b0;
					end else begin
						if (sa_s1 == fqp_pkg::ACT_STRIP) begin
							strip_cnt_d = strip_cnt_q + 1'b1;
						end else if (sa_s1 == fqp_pkg::ACT_LEGAL) begin
							if (seq_cnt_q != '1) seq_cnt_d = seq_cnt_q + 1'b1;
							res_v    = 1'b1;
							res_kind = fqp_pkg::KIND_SEQ;
							res_val  = map_s1;
						end else if (sa_s1 == fqp_pkg::ACT_FATAL && !line_bad_q) begin
							line_bad_d = 1'b1;
							bad_byte_d = byte_s1;
						end
						at_ls_d = 1'b0;
						if (byte_s1 == fqp_pkg::CH_LF) begin
							if (line_bad_d) begin
								phase_d  = fqp_pkg::PH_HALT;
								res_v    = 1'b1;
								res_kind = fqp_pkg::KIND_ERROR;
								res_val  = fqp_pkg::ERR_SEQ_CHAR;
								res_bad  = bad_byte_d;
							end else begin
								line_d  = line_q + 1'b1;
								at_ls_d = 1'b1;
								flp_d   = 1'b0;
							end
						end
					end
				end
				fqp_pkg::PH_PLUS: begin
					if (plus_len_q == '0) plus_first_d = byte_s1;
					if (plus_len_q < hdr_len_q && plus_len_q < HMAX) begin
						if (hdr_s1 != byte_s1) plus_diff_d = 1'b1;
					end else begin
						plus_diff_d = 1'b1;
					end
					if (plus_len_q <= HMAX) plus_len_d = plus_len_q + 1'b1;
					if (byte_s1 == fqp_pkg::CH_LF) begin
						line_d = line_q + 1'b1;
						if (plus_len_d == hdr_len_q) begin
							bad = plus_diff_d;
						end else begin
							bad = plus_len_d > HW'(2) ||
								(plus_len_d == HW'(2) && plus_first_d != fqp_pkg::CH_CR);
						end
						if (bad) begin
							phase_d = fqp_pkg::PH_HALT;
							res_v   = 1'b1;
							res_val = fqp_pkg::ERR_PLUS_LINE;
						end else begin
							phase_d    = fqp_pkg::PH_QUAL;
							at_ls_d    = 1'b1;
							flp_d      = 1'b1;
							line_bad_d = 1'b0;
							qual_cnt_d = '0;
						end
					end
				end
				fqp_pkg::PH_QUAL: begin
					if (at_ls_q && !flp_q && byte_s1 == fqp_pkg::CH_AT &&
						qual_cnt_q == seq_cnt_q) begin
						rec_cnt_d   = rec_cnt_q + 1'b1;
						res_v       = 1'b1;
						res_kind    = fqp_pkg::KIND_END;
						res_len     = 24'(seq_cnt_q);
						res_line    = rec_start_q;
						phase_d     = fqp_pkg::PH_HEAD;
						hdr_len_d   = '0;
						rec_start_d = line_q;
						seq_cnt_d   = '0;
						qual_cnt_d  = '0;
						line_bad_d  = 1'b0;
					end else begin
						if (qa_s1 == fqp_pkg::ACT_STRIP) begin
							strip_cnt_d = strip_cnt_q + 1'b1;
						end else if (qa_s1 == fqp_pkg::ACT_LEGAL) begin
							if (qual_cnt_q != '1) qual_cnt_d = qual_cnt_q + 1'b1;
							res_v    = 1'b1;
							res_kind = fqp_pkg::KIND_QUAL;
							res_val  = byte_s1;
						end else if (qa_s1 == fqp_pkg::ACT_FATAL && !line_bad_q) begin
							line_bad_d = 1'b1;
							bad_byte_d = byte_s1;
						end
						at_ls_d = 1'b0;
						if (byte_s1 == fqp_pkg::CH_LF) begin
							if (qual_cnt_d > seq_cnt_q) begin
								phase_d  = fqp_pkg::PH_HALT;
								res_v    = 1'b1;
								res_kind = fqp_pkg::KIND_ERROR;
								res_val  = fqp_pkg::ERR_LENGTHS;
							end else if (line_bad_d) begin
								phase_d  = fqp_pkg::PH_HALT;
								res_v    = 1'b1;
								res_kind = fqp_pkg::KIND_ERROR;
								res_val  = fqp_pkg::ERR_QUAL_CHAR;
								res_bad  = bad_byte_d;
							end else begin
								line_d  = line_q + 1'b1;
								at_ls_d = 1'b1;
								flp_d   = 1'b0;
							end
						end
					end
				end
				default: ;
			endcase
		end else if (exec && cmd_s1 == fqp_pkg::CMD_EOF) begin
			case (phase_q)
				fqp_pkg::PH_HEAD, fqp_pkg::PH_PLUS: begin
					phase_d = fqp_pkg::PH_HALT;
					res_v   = 1'b1;
					res_val = fqp_pkg::ERR_EOF;
				end
				fqp_pkg::PH_SEQ: begin
					phase_d = fqp_pkg::PH_HALT;
					res_v   = 1'b1;
					if (line_bad_q) begin
						res_val = fqp_pkg::ERR_SEQ_CHAR;
						res_bad = bad_byte_q;
					end else begin
						res_val = fqp_pkg::ERR_EOF;
					end
				end
				fqp_pkg::PH_QUAL: begin
					// A final line feed already advanced the line count.
					eof_line = (at_ls_q && !flp_q) ? line_q - 1'b1 : line_q;
					if (line_bad_q) begin
						phase_d = fqp_pkg::PH_HALT;
						res_v   = 1'b1;
						if (qual_cnt_q > seq_cnt_q) begin
							res_val = fqp_pkg::ERR_LENGTHS;
						end else begin
							res_val = fqp_pkg::ERR_QUAL_CHAR;
							res_bad = bad_byte_q;
						end
					end else if (qual_cnt_q != seq_cnt_q) begin
						phase_d  = fqp_pkg::PH_HALT;
						res_v    = 1'b1;
						res_val  = fqp_pkg::ERR_LENGTHS;
						res_line = eof_line;
					end else begin
						rec_cnt_d = rec_cnt_q + 1'b1;
						phase_d   = fqp_pkg::PH_IDLE;
						res_v     = 1'b1;
						res_kind  = fqp_pkg::KIND_END;
						res_len   = 24'(seq_cnt_q);
						res_line  = rec_start_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			out_v_q      <= 1'b0;
			phase_q      <= fqp_pkg::PH_IDLE;
			hdr_len_q    <= '0;
			plus_len_q   <= '0;
			plus_diff_q  <= 1'b0;
			plus_first_q <= '0;
			seq_cnt_q    <= '0;
			qual_cnt_q   <= '0;
			at_ls_q      <= 1'b0;
			flp_q        <= 1'b1;
			line_bad_q   <= 1'b0;
			bad_byte_q   <= '0;
			line_q       <= 32'd1;
			rec_start_q  <= 32'd1;
			rec_cnt_q    <= '0;
			strip_cnt_q  <= '0;
		end else begin
			if (item_ready) v_s1 <= item_valid;
			if (exec && res_v) begin
				out_v_q <= 1'b1;
			end else if (result_ready) begin
				out_v_q <= 1'b0;
			end
			phase_q      <= phase_d;
			hdr_len_q    <= hdr_len_d;
			plus_len_q   <= plus_len_d;
			plus_diff_q  <= plus_diff_d;
			plus_first_q <= plus_first_d;
			seq_cnt_q    <= seq_cnt_d;
			qual_cnt_q   <= qual_cnt_d;
			at_ls_q      <= at_ls_d;
			flp_q        <= flp_d;
			line_bad_q   <= line_bad_d;
			bad_byte_q   <= bad_byte_d;
			line_q       <= line_d;
			rec_start_q  <= rec_start_d;
			rec_cnt_q    <= rec_cnt_d;
			strip_cnt_q  <= strip_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (exec && res_v) begin
			out_q.kind           <= res_kind;
			out_q.value          <= res_val;
			out_q.record_length  <= res_len;
			out_q.record_number  <= rec_cnt_d;
			out_q.line_number    <= res_line;
			out_q.illegal_byte   <= res_bad;
			out_q.stripped_total <= strip_cnt_d;
		end
	end

endmodule

// ===== tb/sv/fastq_record_parser_test.sv =====
// Self-checking testbench for the FASTQ record parser: random FASTQ text against a predictor.
`timescale 1ns / 1ps

module fastq_record_parser_test;
	import fqp_pkg::*;

	localparam int      MAXH    = MAX_HEADER_DEF;
	localparam int      LEN_CAP = (1 << LENGTH_BITS_DEF) - 1;
	// Rough total of requests in the run, table loads included.
	localparam int      N_ITEMS = 1250;

	typedef struct {
		item_t it;
		bit    drain;
	} pending_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	fastq_record_parser dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	// Parser state as predicted from the accepted requests.
	phase_t      ph;
	logic [7:0]  hdr_text [MAXH];
	int          hdr_len, plus_len;
	bit          plus_differs;
	logic [7:0]  plus_first;
	int          seq_cnt, qual_cnt;
	bit          at_start, first_pend, line_bad;
	logic [7:0]  bad_byte;
	logic [31:0] line_cnt, rec_line, rec_cnt, strip_cnt;
	logic [2:0]  seq_act [256];
	logic [2:0]  qual_act [256];
	logic [7:0]  seq_map [256];
	bit          pr_got;
	result_t     pr_res;

	// Table contents as known when the stimulus is built.
	logic [2:0]  gen_seq_act [256];
	logic [2:0]  gen_qual_act [256];
	logic [7:0]  gen_hdr [512];

	pending_t    pend_q[$];
	result_t     expected_q[$];
	int          errors, n_acc, n_checked, n_records, n_errs_seen;
	int          send_idle, recv_idle;
	logic        hold;

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	function automatic void emit(logic [2:0] k, logic [7:0] v, int len, logic [31:0] line,
			logic [7:0] bad);
		pr_got = 1'b1;
		pr_res.kind = k;
		pr_res.value = v;
		pr_res.record_length = len[23:0];
		pr_res.record_number = rec_cnt;
		pr_res.line_number = line;
		pr_res.illegal_byte = bad;
		pr_res.stripped_total = strip_cnt;
	endfunction

	function automatic void halt_with(logic [7:0] code, logic [31:0] line, logic [7:0] bad);
		ph = PH_HALT;
		emit(KIND_ERROR, code, 0, line, bad);
	endfunction

	function automatic void open_header();
		ph = PH_HEAD;
		hdr_len = 0;
		rec_line = line_cnt;
		seq_cnt = 0;
		qual_cnt = 0;
		line_bad = 1'b0;
	endfunction

	function automatic int bump(int c);
		return (c < LEN_CAP) ? c + 1 : c;
	endfunction

	function automatic void classify(logic [2:0] act, logic [7:0] b, bit is_seq);
		if (act == ACT_STRIP) begin
			strip_cnt++;
		end else if (act == ACT_LEGAL) begin
			if (is_seq) begin
				seq_cnt = bump(seq_cnt);
				emit(KIND_SEQ, seq_map[b], 0, line_cnt, 8'd0);
			end else begin
				qual_cnt = bump(qual_cnt);
				emit(KIND_QUAL, b, 0, line_cnt, 8'd0);
			end
		end else if (act == ACT_FATAL && !line_bad) begin
			line_bad = 1'b1;
			bad_byte = b;
		end
	endfunction

	function automatic void parse_step(item_t it);
		logic [7:0]  b;
		logic [31:0] line;
		bit          bad;
		b = it.byte_value;
		line = line_cnt;
		pr_got = 1'b0;
		case (it.command)
			CMD_LOAD_SEQ: seq_act[b] = it.table_value[2:0];
			CMD_LOAD_QUA: qual_act[b] = it.table_value[2:0];
			CMD_LOAD_MAP: seq_map[b] = it.table_value;
			CMD_EOF: begin
				case (ph)
					PH_HEAD, PH_PLUS: halt_with(ERR_EOF, line_cnt, 8'd0);
					PH_SEQ: begin
						if (line_bad) halt_with(ERR_SEQ_CHAR, line_cnt, bad_byte);
						else halt_with(ERR_EOF, line_cnt, 8'd0);
					end
					PH_QUAL: begin
						if (line_bad) begin
							if (qual_cnt > seq_cnt) halt_with(ERR_LENGTHS, line_cnt, 8'd0);
							else halt_with(ERR_QUAL_CHAR, line_cnt, bad_byte);
						end else begin
							if (at_start && !first_pend) line = line_cnt - 1;
							if (qual_cnt != seq_cnt) begin
								halt_with(ERR_LENGTHS, line, 8'd0);
							end else begin
								rec_cnt++;
								ph = PH_IDLE;
								emit(KIND_END, 8'd0, seq_cnt, rec_line, 8'd0);
							end
						end
					end
					default: ;
				endcase
			end
			CMD_TEXT: begin
				case (ph)
					PH_IDLE: begin
						if (b != CH_AT) halt_with(ERR_NO_AT, line, 8'd0);
						else open_header();
					end
					PH_HEAD: begin
						if (hdr_len < MAXH) hdr_text[hdr_len] = b;
						if (hdr_len <= MAXH) hdr_len++;
						if (b == CH_LF) begin
							line_cnt++;
							ph = PH_SEQ;
							at_start = 1'b1;
							first_pend = 1'b1;
							line_bad = 1'b0;
						end
						emit(KIND_HEADER, b, 0, line, 8'd0);
					end
					PH_SEQ: begin
						if (at_start && !first_pend && b == CH_PLUS) begin
							ph = PH_PLUS;
							plus_len = 0;
							plus_differs = 1'b0;
							plus_first = 8'd0;
							at_start = 1'b0;
						end else begin
							classify(seq_act[b], b, 1'b1);
							at_start = 1'b0;
							if (b == CH_LF) begin
								if (line_bad) begin
									halt_with(ERR_SEQ_CHAR, line, bad_byte);
								end else begin
									line_cnt++;
									at_start = 1'b1;
									first_pend = 1'b0;
								end
							end
						end
					end
					PH_PLUS: begin
						if (plus_len == 0) plus_first = b;
						if (plus_len < hdr_len && plus_len < MAXH) begin
							if (hdr_text[plus_len] != b) plus_differs = 1'b1;
						end else begin
							plus_differs = 1'b1;
						end
						if (plus_len <= MAXH) plus_len++;
						if (b == CH_LF) begin
							line_cnt++;
							if (plus_len == hdr_len) bad = plus_differs;
							else bad = plus_len > 2 || (plus_len == 2 && plus_first != CH_CR);
							if (bad) begin
								halt_with(ERR_PLUS_LINE, line, 8'd0);
							end else begin
								ph = PH_QUAL;
								at_start = 1'b1;
								first_pend = 1'b1;
								line_bad = 1'b0;
								qual_cnt = 0;
							end
						end
					end
					PH_QUAL: begin
						if (at_start && !first_pend && b == CH_AT && qual_cnt == seq_cnt) begin
							rec_cnt++;
							emit(KIND_END, 8'd0, seq_cnt, rec_line, 8'd0);
							open_header();
						end else begin
							classify(qual_act[b], b, 1'b0);
							at_start = 1'b0;
							if (b == CH_LF) begin
								if (qual_cnt > seq_cnt) begin
									halt_with(ERR_LENGTHS, line, 8'd0);
								end else if (line_bad) begin
									halt_with(ERR_QUAL_CHAR, line, bad_byte);
								end else begin
									line_cnt++;
									at_start = 1'b1;
									first_pend = 1'b0;
								end
							end
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
	endtask

	// Stimulus building.
	task automatic push(logic [2:0] cmd, logic [7:0] b, logic [7:0] tv, bit drain = 1'b0);
		pending_t p;
		p.it.command = cmd;
		p.it.byte_value = b;
		p.it.table_value = tv;
		p.drain = drain;
		pend_q.push_back(p);
	endtask

	function automatic logic [2:0] pick_action(logic [7:0] b);
		int r;
		r = $urandom_range(0, 99);
		// Line feeds must never be fatal or counted, so that line lengths stay predictable.
		if (b == CH_LF) return (r < 50) ? ACT_STRIP : 3'($urandom_range(3, 7));
		if (r < 50) return ACT_LEGAL;
		if (r < 65) return ACT_STRIP;
		if (r < 75) return ACT_FATAL;
		return 3'($urandom_range(3, 7));
	endfunction

	task automatic load_entry(logic [7:0] b);
		logic [2:0] a;
		a = pick_action(b);
		gen_seq_act[b] = a;
		push(CMD_LOAD_SEQ, b, {5'($urandom), a});
		a = pick_action(b);
		gen_qual_act[b] = a;
		push(CMD_LOAD_QUA, b, {5'($urandom), a});
		push(CMD_LOAD_MAP, b, 8'($urandom));
	endtask

	function automatic logic [7:0] pick_seq(bit line_start);
		logic [7:0] b;
		do b = 8'($urandom);
		while (gen_seq_act[b] == ACT_FATAL || b == CH_LF || (line_start && b == CH_PLUS));
		return b;
	endfunction

	function automatic logic [7:0] pick_qual(bit line_start);
		logic [7:0] b;
		do b = 8'($urandom);
		while (gen_qual_act[b] == ACT_FATAL || b == CH_LF || (line_start && b == CH_AT));
		return b;
	endfunction

	// plus_style: 0 empty, 1 lone CR, 2 copy of the header.
	task automatic gen_record(int hdr_n, int plus_style, int max_seq, bit drain = 1'b0);
		int         need, nlines, len;
		logic [7:0] b;
		push(CMD_TEXT, CH_AT, 8'($urandom), drain);
		for (int i = 0; i < hdr_n; i++) begin
			do b = 8'($urandom); while (b == CH_LF);
			gen_hdr[i] = b;
			push(CMD_TEXT, b, 8'($urandom));
		end
		push(CMD_TEXT, CH_LF, 8'($urandom));
		need = 0;
		nlines = $urandom_range(1, 3);
		for (int l = 0; l < nlines; l++) begin
			len = $urandom_range(0, max_seq);
			for (int k = 0; k < len; k++) begin
				b = pick_seq(k == 0);
				if (gen_seq_act[b] == ACT_LEGAL) need++;
				push(CMD_TEXT, b, 8'($urandom));
			end
			push(CMD_TEXT, CH_LF, 8'($urandom));
		end
		push(CMD_TEXT, CH_PLUS, 8'($urandom));
		if (plus_style == 1) push(CMD_TEXT, CH_CR, 8'($urandom));
		if (plus_style == 2)
			for (int i = 0; i < hdr_n; i++) push(CMD_TEXT, gen_hdr[i], 8'($urandom));
		push(CMD_TEXT, CH_LF, 8'($urandom));
		do begin
			len = $urandom_range(1, 12);
			for (int k = 0; k < len; k++) begin
				b = pick_qual(k == 0);
				if (gen_qual_act[b] == ACT_LEGAL) begin
					if (need == 0) continue;
					need--;
				end
				push(CMD_TEXT, b, 8'($urandom));
			end
			push(CMD_TEXT, CH_LF, 8'($urandom));
		end while (need > 0);
	endtask

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		bit nv;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			nv = 1'b0;
			if (item_valid && item_ready) begin
				parse_step(item);
				if (pr_got) expected_q.push_back(pr_res);
				void'(pend_q.pop_front());
				n_acc++;
			end
			if (item_valid && !item_ready) begin
				nv = 1'b1;
			end else if (pend_q.size() > 0 && !(pend_q[0].drain && expected_q.size() > 0)
					&& $urandom_range(0, 99) >= send_idle) begin
				nv = 1'b1;
				item <= pend_q[0].it;
			end
			item_valid <= nv;
		end
	end

	// Monitor and receiver.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected result, kind", 32'(result.kind), 32'd0);
				end else begin
					want = expected_q.pop_front();
					n_checked++;
					if (want.kind == KIND_END) n_records++;
					if (want.kind == KIND_ERROR) n_errs_seen++;
					if (result.kind != want.kind) report("kind", result.kind, want.kind);
					if (result.value != want.value) report("value", result.value, want.value);
					if (result.record_length != want.record_length)
						report("record_length", result.record_length, want.record_length);
					if (result.record_number != want.record_number)
						report("record_number", result.record_number, want.record_number);
					if (result.line_number != want.line_number)
						report("line_number", result.line_number, want.line_number);
					if (result.illegal_byte != want.illegal_byte)
						report("illegal_byte", result.illegal_byte, want.illegal_byte);
					if (result.stripped_total != want.stripped_total)
						report("stripped_total", result.stripped_total, want.stripped_total);
				end
			end
			result_ready <= !hold && ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// Idle rates by progress, and one long receiver hold-off.
	always @(posedge clk) begin
		if (n_acc < 1000) begin
			send_idle <= 6;
			recv_idle <= 53;
		end else if (n_acc < 1120) begin
			send_idle <= 53;
			recv_idle <= 6;
		end else begin
			send_idle <= 0;
			recv_idle <= 0;
		end
	end

	initial begin
		hold <= 1'b0;
		wait (n_acc >= 800);
		@(posedge clk);
		hold <= 1'b1;
		repeat (300) @(posedge clk);
		hold <= 1'b0;
	end

	initial begin
		#3ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		errors = 0;
		n_acc = 0;
		n_checked = 0;
		n_records = 0;
		n_errs_seen = 0;
		send_idle = 6;
		recv_idle = 53;
		ph = PH_IDLE;
		hdr_len = 0;
		plus_len = 0;
		plus_differs = 1'b0;
		plus_first = 8'd0;
		seq_cnt = 0;
		qual_cnt = 0;
		at_start = 1'b0;
		first_pend = 1'b1;
		line_bad = 1'b0;
		bad_byte = 8'd0;
		line_cnt = 1;
		rec_line = 1;
		rec_cnt = 0;
		strip_cnt = 0;

		// Every table entry is loaded before any text is parsed.
		for (int i = 0; i < 256; i++) load_entry(8'(i));
		// Directed records: header-equal, lone CR and empty plus lines, empty header,
		// end of file between records, unknown commands, an overlong header.
		gen_record(5, 2, 6);
		gen_record(3, 1, 6);
		gen_record(0, 2, 4);
		push(CMD_EOF, 8'hFF, 8'hFF);
		push(CMD_EOF, 8'h00, 8'h00);
		push(3'd5, 8'hAA, 8'h55);
		push(3'd7, 8'h55, 8'hAA);
		gen_record(MAXH + 4, 0, 3);
		gen_record(2, 0, 0);
		push(CMD_EOF, 8'h00, 8'h00);

		// Random records fill the run up to its planned size, leaving room for the tail.
		while (pend_q.size() < N_ITEMS - 80) begin
			case ($urandom_range(0, 9))
				0: push(CMD_EOF, 8'($urandom), 8'($urandom));
				1: load_entry(8'($urandom));
				default: ;
			endcase
			gen_record($urandom_range(0, 8), $urandom_range(0, 2), 10,
				$urandom_range(0, 19) == 0);
		end
		// A record paused until all results are in, then a garbled tail that ends the parse.
		gen_record($urandom_range(1, 6), 2, 8, 1'b1);
		for (int i = 0; i < 40; i++)
			push(3'($urandom_range(0, 7)) & ($urandom_range(0, 3) == 0 ? 3'd7 : 3'd0),
				8'($urandom), 8'($urandom));
		push(CMD_EOF, 8'd0, 8'd0);
		push(CMD_TEXT, CH_AT, 8'd0);

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (pend_q.size() == 0);
		while (expected_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_q.size() > 0) begin
			report("results never arrived, count", 32'(expected_q.size()), 32'd0);
		end
		$display("Run: %0d requests accepted, %0d results checked, %0d records completed,",
			n_acc, n_checked, n_records);
		$display("     %0d parse errors reported, %0d mismatches.", n_errs_seen, errors);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
